>>> rtl/scod_pkg.sv
`timescale 1ns / 1ps

package scod_pkg;

    // geometry of the reference scan
    localparam int SCAN_POINTS_DEFAULT = 360;

    // field widths
    localparam int ANGLE_W = 9;
    localparam int RANGE_W = 16;
    localparam int HITS_W  = 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAX    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_LIMIT    = 3'd5;

    // register reset values
    localparam logic [ANGLE_W-1:0] WINDOW_START_RST = 9'd345;
    localparam logic [ANGLE_W-1:0] WINDOW_END_RST   = 9'd15;
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST    = 16'd120;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST    = 16'd3500;
    localparam logic [RANGE_W-1:0] DIFF_THRESH_RST  = 16'd400;
    localparam logic [HITS_W-1:0]  HIT_LIMIT_RST    = 8'd15;

    localparam logic [HITS_W-1:0]  HITS_MAX = 8'hFF;

    // one reference scan entry: nan flag and range
    typedef struct packed {
        logic               nan;
        logic [RANGE_W-1:0] range;
    } ref_entry_t;

endpackage

>>> rtl/scod_ref_store.sv
`timescale 1ns / 1ps

module scod_ref_store #(
    parameter int DEPTH  = scod_pkg::SCAN_POINTS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  scod_pkg::ref_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output scod_pkg::ref_entry_t rd_data
);
    import scod_pkg::*;

    ref_entry_t mem [DEPTH];
    ref_entry_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/scan_change_obstacle_detector_top.sv
`timescale 1ns / 1ps

// Scan change obstacle detector. Store beats (func=0) write a reference scan
// entry into an on-chip memory; compare beats (func=1) read that entry and
// count range changes inside the angle window. One beat is accepted every
// cycle while the result register drains; a result beat passes through the
// registered read of the reference memory and the compare stage behind it
// into the result register. Input stalls only while a result waits in the
// output register and out_ready is low. The reference memory needs no
// initialization pass; entries must be stored before they are compared.
module scan_change_obstacle_detector_top #(
    parameter int SCAN_POINTS = scod_pkg::SCAN_POINTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scod_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scod_pkg::CFG_DATA_W-1:0]  cfg_data,
    // sample beats
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [scod_pkg::ANGLE_W-1:0]     angle,
    input  logic [scod_pkg::RANGE_W-1:0]     range_mm,
    input  logic                             is_nan,
    input  logic                             last_of_scan,
    // result beats
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             detected,
    output logic [scod_pkg::HITS_W-1:0]      hits
);
    import scod_pkg::*;

    localparam int ADDR_W = $clog2(SCAN_POINTS);

    // configuration registers
    logic [ANGLE_W-1:0] window_start_reg;
    logic [ANGLE_W-1:0] window_end_reg;
    logic [RANGE_W-1:0] range_min_reg;
    logic [RANGE_W-1:0] range_max_reg;
    logic [RANGE_W-1:0] diff_thresh_reg;
    logic [HITS_W-1:0]  hit_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= WINDOW_START_RST;
            window_end_reg   <= WINDOW_END_RST;
            range_min_reg    <= RANGE_MIN_RST;
            range_max_reg    <= RANGE_MAX_RST;
            diff_thresh_reg  <= DIFF_THRESH_RST;
            hit_limit_reg    <= HIT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_START: window_start_reg <= cfg_data[ANGLE_W-1:0];
                REG_WINDOW_END:   window_end_reg   <= cfg_data[ANGLE_W-1:0];
                REG_RANGE_MIN:    range_min_reg    <= cfg_data;
                REG_RANGE_MAX:    range_max_reg    <= cfg_data;
                REG_DIFF_THRESH:  diff_thresh_reg  <= cfg_data;
                REG_HIT_LIMIT:    hit_limit_reg    <= cfg_data[HITS_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline control
    logic in_fire;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_fire;
    logic res_valid;

    assign in_fire = in_valid && in_ready;

    // stage 0: address check, window and range qualification
    logic              angle_ok;
    logic              win_ok;
    logic              range_ok;
    logic [ADDR_W-1:0] addr;

    assign angle_ok = 32'(angle) < SCAN_POINTS;
    assign addr     = ADDR_W'(angle);
    assign range_ok = (range_mm >= range_min_reg) && (range_mm <= range_max_reg);

    always_comb
    begin
        if (window_start_reg == window_end_reg)
        begin
            win_ok = 1'b0;
        end
        else if (window_start_reg < window_end_reg)
        begin
            win_ok = (angle >= window_start_reg) && (angle < window_end_reg);
        end
        else
        begin
            win_ok = (angle >= window_start_reg) || (angle < window_end_reg);
        end
    end

    // reference memory: stores write at accept, compares read at accept
    ref_entry_t wr_entry;
    ref_entry_t rd_entry;

    assign wr_entry.nan   = is_nan;
    assign wr_entry.range = range_mm;

    scod_ref_store #(
        .DEPTH  (SCAN_POINTS),
        .ADDR_W (ADDR_W)
    ) u_ref_store (
        .clk     (clk),
        .wr_en   (in_fire && !func && angle_ok),
        .wr_addr (addr),
        .wr_data (wr_entry),
        .rd_en   (in_fire && func && angle_ok),
        .rd_addr (addr),
        .rd_data (rd_entry)
    );

    // stage 1 payload
    logic               s1_elig_reg;
    logic               s1_last_reg;
    logic [RANGE_W-1:0] s1_range_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_elig_reg  <= angle_ok && win_ok && !is_nan && range_ok;
            s1_last_reg  <= last_of_scan;
            s1_range_reg <= range_mm;
        end
    end

    // stage 1: compare against reference and update scan state
    logic [HITS_W-1:0]  hit_count_reg;
    logic [HITS_W-1:0]  hit_count_next;
    logic               reported_reg;
    logic               reported_next;
    logic               cmp;
    logic [RANGE_W-1:0] diff;
    logic [HITS_W-1:0]  hit_inc;
    logic               det;

    always_comb
    begin
        cmp  = s1_elig_reg && !rd_entry.nan;
        diff = (s1_range_reg >= rd_entry.range) ? (s1_range_reg - rd_entry.range)
                                                : (rd_entry.range - s1_range_reg);
        hit_inc = hit_count_reg;
        if (cmp && (diff > diff_thresh_reg) && (hit_count_reg != HITS_MAX))
        begin
            hit_inc = hit_count_reg + 8'd1;
        end
        det       = cmp && !reported_reg && (hit_inc >= hit_limit_reg);
        res_valid = s1_valid_reg && (det || (s1_last_reg && !reported_reg));
    end

    logic out_valid_reg;
    logic out_valid_next;

    assign s1_fire  = s1_valid_reg && (!res_valid || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_fire && func)
        begin
            s1_valid_next = 1'b1;
        end

        hit_count_next = hit_count_reg;
        reported_next  = reported_reg;
        if (s1_fire)
        begin
            hit_count_next = s1_last_reg ? '0 : hit_inc;
            reported_next  = s1_last_reg ? 1'b0 : (reported_reg || det);
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hit_count_reg <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            hit_count_reg <= hit_count_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    logic              detected_reg;
    logic [HITS_W-1:0] hits_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            detected_reg <= det;
            hits_reg     <= hit_inc;
        end
    end

    assign out_valid = out_valid_reg;
    assign detected  = detected_reg;
    assign hits      = hits_reg;

endmodule

>>> rtl/scod_checker.sv
`timescale 1ns / 1ps

module scod_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        detected,
    input logic [scod_pkg::HITS_W-1:0] hits
);
    import scod_pkg::*;

    // a waiting result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(detected) && $stable(hits))
        else $error("result beat changed while stalled");

    // input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with result path free");

    // a fresh result follows an accepted input beat through stage 1 and the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without matching input beat");

endmodule

bind scan_change_obstacle_detector_top scod_checker u_scod_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .detected  (detected),
    .hits      (hits)
);

>>> tb/tb_scan_change_obstacle_detector_top.sv
`timescale 1ns / 1ps

module tb_scan_change_obstacle_detector_top;
    import scod_pkg::*;

    localparam int POINTS      = SCAN_POINTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               func;
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] range_mm;
        logic               is_nan;
        logic               last_of_scan;
    } sample_t;

    typedef struct packed {
        logic              detected;
        logic [HITS_W-1:0] hits;
    } detection_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   func         = 1'b0;
    logic [ANGLE_W-1:0]     angle        = '0;
    logic [RANGE_W-1:0]     range_mm     = '0;
    logic                   is_nan       = 1'b0;
    logic                   last_of_scan = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b1;
    logic                   detected;
    logic [HITS_W-1:0]      hits;

    scan_change_obstacle_detector_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .angle        (angle),
        .range_mm     (range_mm),
        .is_nan       (is_nan),
        .last_of_scan (last_of_scan),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .detected     (detected),
        .hits         (hits)
    );

    // stimulus and expectation stores
    sample_t    pending_samples[$];
    detection_t expected_detections[$];
    int         mismatches = 0;
    int         cycles     = 0;

    // detector image: reference scan, scan state and register shadows
    logic [RANGE_W-1:0] scan_ref_range [0:POINTS-1];
    logic               scan_ref_nan   [0:POINTS-1];
    logic [HITS_W-1:0]  hit_cnt       = '0;
    logic               reported      = 1'b0;
    logic [ANGLE_W-1:0] win_start     = WINDOW_START_RST;
    logic [ANGLE_W-1:0] win_end       = WINDOW_END_RST;
    logic [RANGE_W-1:0] min_range     = RANGE_MIN_RST;
    logic [RANGE_W-1:0] max_range     = RANGE_MAX_RST;
    logic [RANGE_W-1:0] change_thresh = DIFF_THRESH_RST;
    logic [HITS_W-1:0]  hit_goal      = HIT_LIMIT_RST;

    // reference ranges as queued, used to aim samples around the threshold
    logic [RANGE_W-1:0] queued_ref [0:POINTS-1];

    // handshake bookkeeping and idling controls
    logic beat_taken    = 1'b0;
    logic sender_bursty = 1'b1;
    logic recv_stalls   = 1'b1;
    int   gap_left      = 0;
    int   burst_left    = 0;
    int   ready_run     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic angle_in_window(input logic [ANGLE_W-1:0] a);
        if (win_start == win_end)
            return 1'b0;
        if (win_start < win_end)
            return a >= win_start && a < win_end;
        return a >= win_start || a < win_end;
    endfunction

    // register write seen on the config port
    task automatic shadow_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_WINDOW_START: win_start     = val[ANGLE_W-1:0];
            REG_WINDOW_END:   win_end       = val[ANGLE_W-1:0];
            REG_RANGE_MIN:    min_range     = val;
            REG_RANGE_MAX:    max_range     = val;
            REG_DIFF_THRESH:  change_thresh = val;
            REG_HIT_LIMIT:    hit_goal      = val[HITS_W-1:0];
            default: ;
        endcase
    endtask

    // append one expected result beat
    task automatic enqueue_detection(input logic det, input logic [HITS_W-1:0] cnt);
        detection_t d;
        d.detected = det;
        d.hits     = cnt;
        expected_detections.insert(expected_detections.size(), d);
    endtask

    // work out the detection result of one accepted sample
    task automatic predict_detection(input sample_t s);
        logic [RANGE_W-1:0] ref_r;
        logic [RANGE_W-1:0] diff;
        logic               made;
        made = 1'b0;
        if (s.func == 1'b0)
        begin
            if (s.angle < POINTS)
            begin
                scan_ref_range[s.angle] = s.range_mm;
                scan_ref_nan[s.angle]   = s.is_nan;
            end
        end
        else
        begin
            if (s.angle < POINTS && angle_in_window(s.angle) && !s.is_nan &&
                s.range_mm >= min_range && s.range_mm <= max_range &&
                !scan_ref_nan[s.angle])
            begin
                ref_r = scan_ref_range[s.angle];
                diff  = (s.range_mm >= ref_r) ? s.range_mm - ref_r : ref_r - s.range_mm;
                if (diff > change_thresh && hit_cnt != HITS_MAX)
                    hit_cnt = hit_cnt + 1'b1;
                if (!reported && hit_cnt >= hit_goal)
                begin
                    reported = 1'b1;
                    enqueue_detection(1'b1, hit_cnt);
                    made = 1'b1;
                end
            end
            if (s.last_of_scan)
            begin
                if (!made && !reported)
                    enqueue_detection(1'b0, hit_cnt);
                hit_cnt  = '0;
                reported = 1'b0;
            end
        end
    endtask

    task automatic check_detection();
        detection_t e;
        if (expected_detections.size() == 0)
        begin
            $error("unexpected result beat: detected=%0d hits=%0d", detected, hits);
            mismatches++;
        end
        else
        begin
            e = expected_detections.pop_front();
            if (detected !== e.detected)
            begin
                $error("detected mismatch: expected %0d, actual %0d", e.detected, detected);
                mismatches++;
            end
            if (hits !== e.hits)
            begin
                $error("hits mismatch: expected %0d, actual %0d", e.hits, hits);
                mismatches++;
            end
        end
    endtask

    // accepted beats: config shadow, prediction and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_taken <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
                shadow_reg_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_detection({func, angle, range_mm, is_nan, last_of_scan});
            if (out_valid && out_ready)
                check_detection();
        end
        else
        begin
            beat_taken <= 1'b0;
        end
    end

    // sample driver: bursts with random gaps while sender_bursty is set
    always @(negedge clk)
    begin
        if (rst_n && (beat_taken || !in_valid))
        begin
            if (sender_bursty && gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                {func, angle, range_mm, is_nan, last_of_scan} <= pending_samples.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 15);
                    gap_left   <= $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: alternating ready and stall runs, sometimes a long stall, while recv_stalls is set
    always @(negedge clk)
    begin
        if (!recv_stalls)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_run != 0)
        begin
            ready_run <= ready_run - 1;
        end
        else
        begin
            out_ready <= !out_ready;
            if (out_ready)
                ready_run <= ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(0, 4);
            else
                ready_run <= $urandom_range(0, 9);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_sample(input logic f, input logic [ANGLE_W-1:0] a,
                              input logic [RANGE_W-1:0] r, input logic n, input logic l);
        sample_t s;
        s.func         = f;
        s.angle        = a;
        s.range_mm     = r;
        s.is_nan       = n;
        s.last_of_scan = l;
        pending_samples.insert(pending_samples.size(), s);
        if (f == 1'b0 && a < POINTS)
            queued_ref[a] = r;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int ws, input int we, input int mn, input int mx,
                            input int th, input int lim);
        write_reg(REG_WINDOW_START, 16'(ws));
        write_reg(REG_WINDOW_END, 16'(we));
        write_reg(REG_RANGE_MIN, 16'(mn));
        write_reg(REG_RANGE_MAX, 16'(mx));
        write_reg(REG_DIFF_THRESH, 16'(th));
        write_reg(REG_HIT_LIMIT, 16'(lim));
    endtask

    // wait until all samples are in and every result has come out
    task automatic drain();
        while (pending_samples.size() != 0 || in_valid || expected_detections.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [ANGLE_W-1:0] window_angle();
        int span;
        int k;
        if (win_start == win_end)
            return ANGLE_W'($urandom_range(0, 511));
        if (win_start < win_end)
            return ANGLE_W'($urandom_range(win_start, win_end - 1));
        span = POINTS - win_start + win_end;
        k = win_start + $urandom_range(0, span - 1);
        if (k >= POINTS)
            k -= POINTS;
        return ANGLE_W'(k);
    endfunction

    // range aimed just around the change threshold, or inside or outside the limits
    function automatic logic [RANGE_W-1:0] aimed_range(input logic [ANGLE_W-1:0] a);
        int base;
        int v;
        base = (a < POINTS) ? int'(queued_ref[a]) : int'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: v = (min_range <= max_range) ? int'($urandom_range(min_range, max_range))
                                            : int'($urandom_range(0, 65535));
            1, 2:
            begin
                v = int'(change_thresh) + int'($urandom_range(0, 2)) - 1;
                v = ($urandom_range(0, 1) != 0) ? base + v : base - v;
            end
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return RANGE_W'(v);
    endfunction

    // mostly well-formed compare scans, some reference refreshes and noise
    task automatic random_traffic(input int count);
        int               made;
        int               len;
        int               k;
        logic [ANGLE_W-1:0] a;
        made = 0;
        while (made < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
            begin
                add_sample(1'($urandom_range(0, 1)), ANGLE_W'($urandom_range(0, 511)),
                           RANGE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                made++;
            end
            else if (k < 22)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    a = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(360, 511))
                                                    : ANGLE_W'($urandom_range(0, 359));
                    add_sample(1'b0, a,
                               ($urandom_range(0, 1) != 0) ? RANGE_W'($urandom_range(0, 65535))
                                                           : RANGE_W'($urandom_range(100, 4000)),
                               $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
                end
                made += len;
            end
            else
            begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                begin
                    a = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(0, 511))
                                                    : window_angle();
                    add_sample(1'b1, a, aimed_range(a), $urandom_range(0, 11) == 0,
                               (i == len - 1) && ($urandom_range(0, 19) != 0));
                end
                made += len;
            end
        end
    endtask

    initial
    begin
        int a;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole reference scan before any compare, some entries nan
        for (a = 0; a < POINTS; a++)
            add_sample(1'b0, ANGLE_W'(a), RANGE_W'($urandom_range(100, 4000)),
                       $urandom_range(0, 9) == 0, 1'b0);
        add_sample(1'b0, 9'd511, 16'hFFFF, 1'b1, 1'b1);

        // directed samples under the reset register values (window 345..14)
        add_sample(1'b0, 9'd350, 16'd1000, 1'b0, 1'b1);   // last mark on a store
        add_sample(1'b0, 9'd351, 16'd1000, 1'b1, 1'b0);   // nan reference
        add_sample(1'b0, 9'd0, 16'd3500, 1'b0, 1'b0);
        add_sample(1'b0, 9'd14, 16'd120, 1'b0, 1'b0);
        add_sample(1'b0, 9'd400, 16'd5, 1'b0, 1'b0);      // angle out of range
        add_sample(1'b1, 9'd350, 16'd1401, 1'b0, 1'b0);   // just above threshold
        add_sample(1'b1, 9'd350, 16'd1400, 1'b0, 1'b0);   // exactly threshold
        add_sample(1'b1, 9'd350, 16'd599, 1'b0, 1'b0);    // below reference
        add_sample(1'b1, 9'd351, 16'd3000, 1'b0, 1'b0);
        add_sample(1'b1, 9'd350, 16'd3000, 1'b1, 1'b0);   // nan sample
        add_sample(1'b1, 9'd0, 16'd120, 1'b0, 1'b0);      // range at minimum
        add_sample(1'b1, 9'd14, 16'd3500, 1'b0, 1'b0);    // range at maximum
        add_sample(1'b1, 9'd15, 16'd3500, 1'b0, 1'b0);    // window end, excluded
        add_sample(1'b1, 9'd344, 16'd3500, 1'b0, 1'b0);   // just before window
        add_sample(1'b1, 9'd350, 16'd119, 1'b0, 1'b0);
        add_sample(1'b1, 9'd350, 16'd3501, 1'b0, 1'b0);
        add_sample(1'b1, 9'd350, 16'd0, 1'b0, 1'b0);
        add_sample(1'b1, 9'd350, 16'hFFFF, 1'b0, 1'b0);
        add_sample(1'b1, 9'd400, 16'd3000, 1'b0, 1'b0);
        add_sample(1'b1, 9'd511, 16'd3000, 1'b0, 1'b0);
        add_sample(1'b1, 9'd350, 16'd1000, 1'b0, 1'b1);   // scan ends, no detection

        for (int p = 1; p <= 10; p++)
        begin
            drain();
            sender_bursty = $urandom_range(0, 3) != 0;
            recv_stalls   = $urandom_range(0, 3) != 0;
            case (p)
                1:
                begin
                    set_regs(0, 359, 0, 65535, 0, 1);
                    // detection on the last sample of a scan
                    add_sample(1'b0, 9'd20, 16'd500, 1'b0, 1'b0);
                    add_sample(1'b1, 9'd20, 16'd501, 1'b0, 1'b1);
                    random_traffic(90);
                end
                2:
                begin
                    set_regs(359, 0, 0, 65535, 65535, 255);
                    random_traffic(90);
                end
                3:
                begin
                    set_regs(100, 100, 120, 3500, 400, 3);   // empty window
                    random_traffic(70);
                end
                4:
                begin
                    set_regs(300, 60, 200, 4000, 300, 4);
                    random_traffic(110);
                end
                5:
                begin
                    set_regs(0, 359, 5000, 100, 100, 2);     // crossed range limits
                    random_traffic(70);
                end
                6:
                begin
                    set_regs(10, 200, 0, 65535, 1000, 0);    // zero hit limit
                    random_traffic(90);
                end
                7, 8:
                begin
                    set_regs($urandom_range(0, 359), $urandom_range(0, 359),
                             $urandom_range(0, 1000), $urandom_range(2000, 8000),
                             $urandom_range(0, 2000), $urandom_range(1, 6));
                    random_traffic(110);
                end
                9:
                begin
                    // hit count saturation over one long scan
                    set_regs(0, 359, 0, 65535, 0, 255);
                    for (a = 0; a < POINTS; a++)
                        add_sample(1'b0, ANGLE_W'(a), RANGE_W'(1000 + a), 1'b0, 1'b0);
                    for (int i = 0; i < 330; i++)
                    begin
                        a = $urandom_range(0, 358);
                        add_sample(1'b1, ANGLE_W'(a), queued_ref[a] ^ 16'h0001, 1'b0,
                                   i == 329);
                    end
                end
                default:
                begin
                    set_regs(WINDOW_START_RST, WINDOW_END_RST, RANGE_MIN_RST,
                             RANGE_MAX_RST, DIFF_THRESH_RST, HIT_LIMIT_RST);
                    random_traffic(90);
                end
            endcase
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
